### rtl/mips_subset_single_cycle_core_macros.svh
// Assertion macros shared by the core's concurrent checks.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MSSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mssc: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MSSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mssc: next-cycle check failed");

`endif

### rtl/mssc_pkg.sv
// Shared constants and types of the MIPS subset core.
`timescale 1ns / 1ps

package mssc_pkg;

  localparam int DMEM_BYTES_DEF = 1024;
  localparam int IN_TDATA_W     = 56;
  localparam int OUT_TDATA_W    = 120;
  localparam int RF_IDX_W       = 5;

  localparam logic IN_OP_EXEC    = 1'b0;
  localparam logic IN_OP_PRELOAD = 1'b1;

  localparam logic [5:0] OPC_RTYPE = 6'd0;
  localparam logic [5:0] OPC_J     = 6'd2;
  localparam logic [5:0] OPC_BEQ   = 6'd4;
  localparam logic [5:0] OPC_ADDIU = 6'd9;
  localparam logic [5:0] OPC_LW    = 6'd35;
  localparam logic [5:0] OPC_SW    = 6'd43;

  localparam logic [2:0] FN_ADDU = 3'd1;
  localparam logic [2:0] FN_SUBU = 3'd3;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_OR   = 3'd5;
  localparam logic [2:0] FN_NOR  = 3'd7;

  typedef struct packed {
    logic                we;
    logic [RF_IDX_W-1:0] idx;
    logic [31:0]         data;
  } mssc_rf_wr_t;

  typedef struct packed {
    logic load;
    logic store;
    logic preload;
  } mssc_dmem_ctl_t;

endpackage

### rtl/mssc_regfile.sv
// Register file: 32 words in a synchronous memory with reset-cleared valid bits.
`timescale 1ns / 1ps

module mssc_regfile import mssc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [RF_IDX_W-1:0] raddr_a,
  input  logic [RF_IDX_W-1:0] raddr_b,
  input  mssc_rf_wr_t         wr,
  output logic [31:0]         rdata_a,
  output logic [31:0]         rdata_b
);

  localparam int DEPTH = 2 ** RF_IDX_W;

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [31:0]      data_a_r;
  logic [31:0]      data_b_r;
  logic             vld_a_r;
  logic             vld_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx] <= wr.data;
    end
    data_a_r <= mem[raddr_a];
    data_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[wr.idx] <= 1'b1;
      end
      vld_a_r <= valid_r[raddr_a];
      vld_b_r <= valid_r[raddr_b];
    end
  end

  assign rdata_a = vld_a_r ? data_a_r : '0;
  assign rdata_b = vld_b_r ? data_b_r : '0;

endmodule

### rtl/mssc_dmem.sv
// Data memory: four byte-lane banks giving big-endian word access at any byte address.
`timescale 1ns / 1ps

module mssc_dmem import mssc_pkg::*; #(
  parameter int DMEM_BYTES = DMEM_BYTES_DEF
) (
  input  logic                          clk,
  input  mssc_dmem_ctl_t                ctl,
  input  logic [$clog2(DMEM_BYTES)-1:0] addr,
  input  logic [31:0]                   wdata,
  output logic [31:0]                   rdata
);

  localparam int AW   = $clog2(DMEM_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = DMEM_BYTES / 4;

  logic [7:0]    mem [4][ROWS];
  logic [RW-1:0] row [4];
  logic [7:0]    wbyte [4];
  logic [3:0]    we;
  logic [7:0]    lane_q [4];
  logic [1:0]    rot_r;

  always_comb begin
    logic [1:0]  pos;
    logic [31:0] sh;
    for (int k = 0; k < 4; k++) begin
      pos      = 2'(k) - addr[1:0];
      sh       = wdata << {pos, 3'b000};
      row[k]   = addr[AW-1:2] + RW'(2'(k) < addr[1:0]);
      wbyte[k] = ctl.preload ? wdata[7:0] : sh[31:24];
      we[k]    = ctl.store | (ctl.preload & (addr[1:0] == 2'(k)));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (we[k]) begin
        mem[k][row[k]] <= wbyte[k];
      end
      if (ctl.load) begin
        lane_q[k] <= mem[k][row[k]];
      end
    end
    if (ctl.load) begin
      rot_r <= addr[1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata[8*(3-i) +: 8] = lane_q[rot_r + 2'(i)];
    end
  end

endmodule

### rtl/mips_subset_single_cycle_core.sv
// Top level of the MIPS subset core: decode, execute and result pipeline.
// An accepted word passes through the s1, s2 and s3 registers before it reaches out_tdata.
// Throughput: one word per cycle while out_tready is high; a word whose rs or rt field names the register
// loaded by the lw just ahead of it is held in s1 until that lw leaves s2 with the data memory read.
// Reset (rst_n low, synchronous) clears PC, halt, last ALU result and register
// valid bits at once; the data memory keeps its contents and is not cleared.
`timescale 1ns / 1ps
`include "mips_subset_single_cycle_core_macros.svh"

module mips_subset_single_cycle_core import mssc_pkg::*; #(
  parameter int DMEM_BYTES = DMEM_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // instruction_word[31:0], preload_address[41:32], preload_byte[49:42], zero pad.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode[0].
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // next_pc[31:0], halted[32], reg_write_valid[33], reg_write_index[38:34],
  // reg_write_value[70:39], store_valid[71], store_address[81:72],
  // store_word[113:82], zero pad.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int          AW        = $clog2(DMEM_BYTES);
  localparam logic [31:0] ADDR_MASK = 32'(DMEM_BYTES - 1);

  logic in_accept;
  logic s1_move;
  logic s2_move;
  logic load_use_stall;

  logic        s1_v_r;
  logic        s1_op_r;
  logic [31:0] s1_ins_r;
  logic [9:0]  s1_paddr_r;
  logic [7:0]  s1_pbyte_r;

  logic [31:0] pc_r;
  logic        halt_r;
  logic [31:0] last_alu_r;

  logic                s2_v_r;
  logic [31:0]         s2_pc_r;
  logic                s2_halt_r;
  logic                s2_wv_r;
  logic [RF_IDX_W-1:0] s2_widx_r;
  logic [31:0]         s2_wval_r;
  logic                s2_load_r;
  logic                s2_sv_r;
  logic [9:0]          s2_saddr_r;
  logic [31:0]         s2_sword_r;

  logic                   s3_v_r;
  logic [OUT_TDATA_W-1:0] s3_data_r;

  logic                last_we_r;
  logic [RF_IDX_W-1:0] last_idx_r;
  logic [31:0]         last_val_r;

  logic [RF_IDX_W-1:0] rd_addr_a;
  logic [RF_IDX_W-1:0] rd_addr_b;
  logic [31:0]         rf_a;
  logic [31:0]         rf_b;
  mssc_rf_wr_t         rf_wr;

  logic [5:0]          s1_opc;
  logic [RF_IDX_W-1:0] s1_rs;
  logic [RF_IDX_W-1:0] s1_rt;
  logic [RF_IDX_W-1:0] s1_rd;
  logic [31:0]         imm;
  logic [31:0]         op_a;
  logic [31:0]         op_b;
  logic [31:0]         pc4;
  logic [31:0]         npc;
  logic                halt_nxt;
  logic [31:0]         alu_nxt;
  logic                wv;
  logic [RF_IDX_W-1:0] widx;
  logic [31:0]         wval;
  logic                is_load;
  logic                is_store;
  logic                is_preload;
  logic [31:0]         ea_wrap;
  logic [31:0]         pa_wrap;

  mssc_dmem_ctl_t dmem_ctl;
  logic [AW-1:0]  dmem_addr;
  logic [31:0]    dmem_wdata;
  logic [31:0]    dmem_rdata;

  logic [31:0]            fin_wval;
  logic [OUT_TDATA_W-1:0] out_nxt;

  assign in_accept = in_tvalid & in_tready;

  assign s1_opc = s1_ins_r[31:26];
  assign s1_rs  = s1_ins_r[25:21];
  assign s1_rt  = s1_ins_r[20:16];
  assign s1_rd  = s1_ins_r[15:11];
  assign imm    = {{16{s1_ins_r[15]}}, s1_ins_r[15:0]};

  assign load_use_stall = s1_v_r & s2_v_r & s2_load_r & s2_wv_r &
                          ((s2_widx_r == s1_rs) | (s2_widx_r == s1_rt));
  assign s2_move   = s2_v_r & (~s3_v_r | out_tready);
  assign s1_move   = s1_v_r & ~load_use_stall & (~s2_v_r | s2_move);
  assign in_tready = ~s1_v_r | s1_move;

  assign rd_addr_a = in_accept ? in_tdata[25:21] : s1_rs;
  assign rd_addr_b = in_accept ? in_tdata[20:16] : s1_rt;

  mssc_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .wr      (rf_wr),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  always_comb begin
    if (s2_v_r && s2_wv_r && !s2_load_r && s2_widx_r == s1_rs) begin
      op_a = s2_wval_r;
    end else if (last_we_r && last_idx_r == s1_rs) begin
      op_a = last_val_r;
    end else begin
      op_a = rf_a;
    end
    if (s2_v_r && s2_wv_r && !s2_load_r && s2_widx_r == s1_rt) begin
      op_b = s2_wval_r;
    end else if (last_we_r && last_idx_r == s1_rt) begin
      op_b = last_val_r;
    end else begin
      op_b = rf_b;
    end
  end

  assign is_preload = (s1_op_r == IN_OP_PRELOAD);
  assign pc4        = pc_r + 32'd4;
  assign ea_wrap    = (op_a + imm) & ADDR_MASK;
  assign pa_wrap    = {22'b0, s1_paddr_r} & ADDR_MASK;

  always_comb begin
    npc      = pc4;
    halt_nxt = halt_r;
    alu_nxt  = last_alu_r;
    wv       = 1'b0;
    widx     = s1_rd;
    wval     = '0;
    is_load  = 1'b0;
    is_store = 1'b0;
    if (is_preload || halt_r) begin
      npc = pc_r;
    end else begin
      unique case (s1_opc)
        OPC_RTYPE: begin
          unique case (s1_ins_r[2:0])
            FN_ADDU: alu_nxt = op_a + op_b;
            FN_SUBU: alu_nxt = op_a - op_b;
            FN_AND:  alu_nxt = op_a & op_b;
            FN_OR:   alu_nxt = op_a | op_b;
            FN_NOR:  alu_nxt = ~(op_a | op_b);
            default: alu_nxt = last_alu_r;
          endcase
          wv   = 1'b1;
          widx = s1_rd;
          wval = alu_nxt;
        end
        OPC_ADDIU: begin
          wv   = 1'b1;
          widx = s1_rt;
          wval = op_a + imm;
        end
        OPC_BEQ: begin
          if (op_a == op_b) begin
            npc = pc4 + {imm[29:0], 2'b00};
          end
        end
        OPC_J: begin
          npc = {pc4[31:28], s1_ins_r[25:0], 2'b00};
        end
        OPC_LW: begin
          wv      = 1'b1;
          widx    = s1_rt;
          is_load = 1'b1;
        end
        OPC_SW: begin
          is_store = 1'b1;
        end
        default: begin
          halt_nxt = 1'b1;
          npc      = pc_r;
        end
      endcase
    end
    if (widx == '0) begin
      wv = 1'b0;
    end
    if (!wv) begin
      widx = '0;
      wval = '0;
    end
  end

  assign dmem_ctl.load    = s1_move & is_load;
  assign dmem_ctl.store   = s1_move & is_store;
  assign dmem_ctl.preload = s1_move & is_preload;
  assign dmem_addr        = is_preload ? pa_wrap[AW-1:0] : ea_wrap[AW-1:0];
  assign dmem_wdata       = is_preload ? {24'b0, s1_pbyte_r} : op_b;

  mssc_dmem #(
    .DMEM_BYTES (DMEM_BYTES)
  ) u_dmem (
    .clk   (clk),
    .ctl   (dmem_ctl),
    .addr  (dmem_addr),
    .wdata (dmem_wdata),
    .rdata (dmem_rdata)
  );

  assign fin_wval = !s2_wv_r ? '0 : (s2_load_r ? dmem_rdata : s2_wval_r);

  assign rf_wr.we   = s2_move & s2_wv_r;
  assign rf_wr.idx  = s2_widx_r;
  assign rf_wr.data = fin_wval;

  assign out_nxt = {6'b0, s2_sword_r, s2_saddr_r, s2_sv_r, fin_wval, s2_widx_r,
                    s2_wv_r, s2_halt_r, s2_pc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      pc_r       <= '0;
      halt_r     <= 1'b0;
      last_alu_r <= '0;
      last_we_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        s2_v_r     <= 1'b1;
        pc_r       <= npc;
        halt_r     <= halt_nxt;
        last_alu_r <= alu_nxt;
      end else if (s2_move) begin
        s2_v_r <= 1'b0;
      end
      if (s2_move) begin
        s3_v_r <= 1'b1;
      end else if (out_tready) begin
        s3_v_r <= 1'b0;
      end
      last_we_r <= rf_wr.we;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r    <= in_tuser;
      s1_ins_r   <= in_tdata[31:0];
      s1_paddr_r <= in_tdata[41:32];
      s1_pbyte_r <= in_tdata[49:42];
    end
    if (s1_move) begin
      s2_pc_r    <= npc;
      s2_halt_r  <= halt_nxt;
      s2_wv_r    <= wv;
      s2_widx_r  <= widx;
      s2_wval_r  <= wval;
      s2_load_r  <= is_load;
      s2_sv_r    <= is_store;
      s2_saddr_r <= is_store ? ea_wrap[9:0] : '0;
      s2_sword_r <= is_store ? op_b : '0;
    end
    if (s2_move) begin
      s3_data_r <= out_nxt;
    end
    last_idx_r <= rf_wr.idx;
    last_val_r <= rf_wr.data;
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = s3_data_r;

  `MSSC_ASSERT_NXT(a_stall_clears, load_use_stall && s2_move, !load_use_stall)
  `MSSC_ASSERT_NXT(a_halt_sticky, halt_r, halt_r)
  `MSSC_ASSERT_NXT(a_load_bypass, s2_move && s2_load_r && s2_wv_r, last_we_r)

endmodule

### sim/tb_mips_subset_single_cycle_core.sv
// Self-checking testbench that runs directed and random instruction streams through the core.
`timescale 1ns / 1ps

module tb_mips_subset_single_cycle_core;
  import mssc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int MEM_BYTES      = DMEM_BYTES_DEF;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 400000;

  localparam logic [2:0] FN_SPARE0 = 3'd0;
  localparam logic [2:0] FN_SPARE2 = 3'd2;
  localparam logic [2:0] FN_SPARE6 = 3'd6;

  // Result word fields, next_pc in the lowest bits.
  typedef struct packed {
    logic [31:0] store_word;
    logic [9:0]  store_address;
    logic        store_valid;
    logic [31:0] reg_write_value;
    logic [4:0]  reg_write_index;
    logic        reg_write_valid;
    logic        halted;
    logic [31:0] next_pc;
  } core_result_t;

  localparam int RESULT_W = $bits(core_result_t);

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = IN_OP_EXEC;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  bit          rx_hold_req = 1'b0;
  int          errors = 0;
  int unsigned cycle_count = 0;

  // Shadow state of the core.
  logic [31:0] core_pc;
  logic [31:0] gpr [32];
  logic [31:0] last_alu;
  logic        core_halted;
  logic [7:0]  mem_byte [MEM_BYTES];
  bit          byte_written [MEM_BYTES];
  logic [9:0]  word_ready [$];

  core_result_t pending_retire [$];

  mips_subset_single_cycle_core #(
    .DMEM_BYTES(DMEM_BYTES_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void store_byte(input logic [9:0] addr, input logic [7:0] val);
    logic [9:0] s;
    mem_byte[addr] = val;
    if (!byte_written[addr]) begin
      byte_written[addr] = 1'b1;
      for (int k = 0; k < 4; k++) begin
        s = 10'(addr - k);
        if (byte_written[s] && byte_written[10'(s + 1)] && byte_written[10'(s + 2)] &&
            byte_written[10'(s + 3)]) begin
          word_ready.push_back(s);
        end
      end
    end
  endfunction

  function automatic core_result_t retire_item(input logic op, input logic [31:0] ins,
                                               input logic [9:0] paddr,
                                               input logic [7:0] pbyte);
    core_result_t r;
    logic [5:0]   opc;
    logic [4:0]   rs, rt, rd, widx;
    logic [31:0]  a, b, imm, pc4, npc, wval, ea;
    logic         wv;
    r = '0;
    wv = 1'b0;
    widx = '0;
    wval = '0;
    if (op == IN_OP_PRELOAD) begin
      store_byte(paddr, pbyte);
    end else if (!core_halted) begin
      opc = ins[31:26];
      rs  = ins[25:21];
      rt  = ins[20:16];
      rd  = ins[15:11];
      a   = gpr[rs];
      b   = gpr[rt];
      imm = {{16{ins[15]}}, ins[15:0]};
      pc4 = core_pc + 32'd4;
      npc = pc4;
      ea  = a + imm;
      case (opc)
        OPC_RTYPE: begin
          case (ins[2:0])
            FN_ADDU: last_alu = a + b;
            FN_SUBU: last_alu = a - b;
            FN_AND:  last_alu = a & b;
            FN_OR:   last_alu = a | b;
            FN_NOR:  last_alu = ~(a | b);
            default: ;
          endcase
          wv = 1'b1;
          widx = rd;
          wval = last_alu;
        end
        OPC_ADDIU: begin
          wv = 1'b1;
          widx = rt;
          wval = a + imm;
        end
        OPC_BEQ: begin
          if (a == b) npc = pc4 + (imm << 2);
        end
        OPC_J: begin
          npc = {pc4[31:28], ins[25:0], 2'b00};
        end
        OPC_LW: begin
          wv = 1'b1;
          widx = rt;
          for (int k = 0; k < 4; k++) wval = {wval[23:0], mem_byte[10'(ea + k)]};
        end
        OPC_SW: begin
          for (int k = 0; k < 4; k++) store_byte(10'(ea + k), b[31 - 8 * k -: 8]);
          r.store_valid = 1'b1;
          r.store_address = ea[9:0];
          r.store_word = b;
        end
        default: begin
          core_halted = 1'b1;
          npc = core_pc;
        end
      endcase
      if (wv && widx != 5'd0) begin
        gpr[widx] = wval;
        r.reg_write_valid = 1'b1;
        r.reg_write_index = widx;
        r.reg_write_value = wval;
      end
      core_pc = npc;
    end
    r.next_pc = core_pc;
    r.halted = core_halted;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [2:0] fn);
    return {OPC_RTYPE, rs, rt, rd, 5'd0, 3'd0, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  // Low registers are favored so that results are read back soon after they are written.
  function automatic logic [4:0] rand_reg();
    return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
  endfunction

  function automatic logic [31:0] rand_exec_word();
    int unsigned pick;
    logic [4:0]  rs, rt;
    logic [9:0]  target, off;
    pick = $urandom_range(0, 99);
    rs = rand_reg();
    rt = rand_reg();
    if (pick < 30) return {OPC_RTYPE, rs, rt, rand_reg(), 11'($urandom)};
    if (pick < 50) return {OPC_ADDIU, rs, rt, 16'($urandom)};
    if (pick < 60) return {OPC_BEQ, rs, ($urandom_range(0, 1) != 0) ? rs : rt, 16'($urandom)};
    if (pick < 65) return {OPC_J, 26'($urandom)};
    // A load only ever targets a word whose four bytes have been written.
    if (pick < 80 && word_ready.size() != 0) begin
      target = word_ready[$urandom_range(0, word_ready.size() - 1)];
      off = target - gpr[rs][9:0];
      return {OPC_LW, rs, rt, 6'($urandom), off};
    end
    return {OPC_SW, rs, rt, 16'($urandom)};
  endfunction

  task automatic send_item(input logic op, input logic [31:0] ins,
                           input logic [9:0] paddr, input logic [7:0] pbyte);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - 50){1'b0}}, pbyte, paddr, ins};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pending_retire.push_back(retire_item(op, ins, paddr, pbyte));
  endtask

  task automatic send_exec(input logic [31:0] ins);
    send_item(IN_OP_EXEC, ins, 10'($urandom), 8'($urandom));
  endtask

  task automatic send_preload(input logic [9:0] paddr, input logic [7:0] pbyte);
    send_item(IN_OP_PRELOAD, $urandom, paddr, pbyte);
  endtask

  task automatic send_random_item();
    if ($urandom_range(0, 99) < 15) send_preload(10'($urandom), 8'($urandom));
    else send_exec(rand_exec_word());
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_retire.size() != 0) @(posedge clk);
  endtask

  task automatic test_alu_ops();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_exec(enc_i(OPC_ADDIU, 5'd0, 5'd1, 16'h7FFF));
    send_exec(enc_i(OPC_ADDIU, 5'd0, 5'd2, 16'h8000));
    send_exec(enc_i(OPC_ADDIU, 5'd0, 5'd3, 16'hFFFF));
    send_exec(enc_r(5'd3, 5'd3, 5'd4, FN_ADDU));
    send_exec(enc_r(5'd1, 5'd2, 5'd5, FN_SUBU));
    send_exec(enc_r(5'd2, 5'd3, 5'd6, FN_AND));
    send_exec(enc_r(5'd1, 5'd2, 5'd7, FN_OR));
    send_exec(enc_r(5'd0, 5'd0, 5'd8, FN_NOR));
    send_exec(enc_r(5'd1, 5'd2, 5'd9, FN_SPARE0));
    send_exec(enc_r(5'd3, 5'd1, 5'd10, FN_SPARE2));
    send_exec({OPC_RTYPE, 5'd1, 5'd2, 5'd31, 5'd31, 3'b111, FN_SPARE6});
    send_exec(enc_i(OPC_ADDIU, 5'd3, 5'd0, 16'h0001));
    send_exec(enc_r(5'd0, 5'd1, 5'd12, FN_ADDU));
  endtask

  task automatic test_memory_ops();
    send_preload(10'd1023, 8'hFF);
    send_preload(10'd0, 8'h00);
    send_preload(10'd1, 8'hA5);
    send_preload(10'd2, 8'h5A);
    send_exec(enc_i(OPC_LW, 5'd0, 5'd13, 16'h03FF));
    send_exec(enc_i(OPC_SW, 5'd0, 5'd3, 16'hFFFE));
    send_exec(enc_i(OPC_LW, 5'd0, 5'd14, 16'h03FE));
  endtask

  task automatic test_control_flow();
    send_exec(enc_i(OPC_ADDIU, 5'd0, 5'd15, 16'h7FFF));
    send_exec(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'hFFFF));
    send_exec(enc_i(OPC_BEQ, 5'd1, 5'd2, 16'h0010));
    send_exec(enc_i(OPC_BEQ, 5'd1, 5'd15, 16'h7FFF));
    send_exec({OPC_J, 26'h3FFFFFF});
    send_exec({OPC_J, 26'h0000000});
  endtask

  task automatic test_random_mix(input int count, input bit tx_gaps, input bit rx_gaps);
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    repeat (count) send_random_item();
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = 1'b1;
    repeat (60) send_random_item();
  endtask

  task automatic test_sender_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (50) send_random_item();
    wait_results_drained();
    repeat (50) send_random_item();
  endtask

  task automatic test_halt();
    logic [5:0] bad_opc;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    bad_opc = 6'($urandom);
    while (bad_opc == OPC_RTYPE || bad_opc == OPC_J || bad_opc == OPC_BEQ ||
           bad_opc == OPC_ADDIU || bad_opc == OPC_LW || bad_opc == OPC_SW) begin
      bad_opc = 6'($urandom);
    end
    send_exec({bad_opc, 26'($urandom)});
    repeat (80) begin
      if ($urandom_range(0, 99) < 30) send_preload(10'($urandom), 8'($urandom));
      else send_exec($urandom);
    end
  endtask

  initial begin : rx_side
    int gap;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
    end
  end

  task automatic compare_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    core_result_t exp_r;
    core_result_t act_r;
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      act_r = out_tdata[RESULT_W-1:0];
      if (pending_retire.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, act_r);
        errors++;
      end else begin
        exp_r = pending_retire.pop_front();
        compare_field("next_pc", exp_r.next_pc, act_r.next_pc);
        compare_field("halted", 32'(exp_r.halted), 32'(act_r.halted));
        compare_field("reg_write_valid", 32'(exp_r.reg_write_valid),
                      32'(act_r.reg_write_valid));
        compare_field("reg_write_index", 32'(exp_r.reg_write_index),
                      32'(act_r.reg_write_index));
        compare_field("reg_write_value", exp_r.reg_write_value, act_r.reg_write_value);
        compare_field("store_valid", 32'(exp_r.store_valid), 32'(act_r.store_valid));
        compare_field("store_address", 32'(exp_r.store_address), 32'(act_r.store_address));
        compare_field("store_word", exp_r.store_word, act_r.store_word);
      end
    end
  end

  initial begin
    core_pc = '0;
    last_alu = '0;
    core_halted = 1'b0;
    for (int k = 0; k < 32; k++) gpr[k] = '0;
    for (int k = 0; k < MEM_BYTES; k++) begin
      mem_byte[k] = '0;
      byte_written[k] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alu_ops();
    test_memory_ops();
    test_control_flow();
    test_random_mix(700, 1'b1, 1'b1);
    test_random_mix(300, 1'b0, 1'b0);
    test_output_backpressure();
    test_random_mix(300, 1'b1, 1'b0);
    test_random_mix(300, 1'b0, 1'b1);
    test_sender_pause();
    test_halt();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/mssc_pkg.sv
rtl/mssc_regfile.sv
rtl/mssc_dmem.sv
rtl/mips_subset_single_cycle_core.sv
sim/tb_mips_subset_single_cycle_core.sv
